@@ design/bc128_pkg.sv @@
// Shared constants, register codes and the controller-to-datapath command word.
`default_nettype none

package bc128_pkg;

  localparam int ROUNDS_DEF = 14;
  localparam int HALF_W     = 64;
  localparam int WORD_W     = 32;
  localparam int BLOCK_W    = 128;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(1);

  localparam logic [WORD_W-1:0] KS_MAT   = 32'hb881b9ca;
  localparam logic [WORD_W-1:0] KS_RC0   = 32'h00000080;
  localparam logic [WORD_W-1:0] KS_RC1   = 32'h00006a00;
  localparam logic [WORD_W-1:0] KS_RC2   = 32'h003f0000;
  localparam logic [WORD_W-1:0] KS_RC3   = 32'h24000000;

  localparam logic [WORD_W-1:0] ENC_MAT0 = 32'ha3861085;
  localparam logic [WORD_W-1:0] ENC_MAT1 = 32'h63417021;
  localparam logic [WORD_W-1:0] ENC_MAT2 = 32'h692cf280;
  localparam logic [WORD_W-1:0] ENC_MAT3 = 32'h48a54813;

  localparam logic [WORD_W-1:0] DEC_MAT0 = 32'h2037a121;
  localparam logic [WORD_W-1:0] DEC_MAT1 = 32'h108ff2a0;
  localparam logic [WORD_W-1:0] DEC_MAT2 = 32'h9054d8c0;
  localparam logic [WORD_W-1:0] DEC_MAT3 = 32'h3354b117;

  typedef struct packed {
    logic key_wr_hi;
    logic key_wr_lo;
    logic load_in;
    logic load_key;
    logic exp_step;
    logic round;
    logic first;
    logic last;
    logic rk_use_in;
    logic out_load;
    logic out_from_round;
  } bc_cmd_t;

endpackage

`default_nettype wire

@@ design/block_cipher_128_encrypt_decrypt.sv @@
// Top level of the 128-bit block cipher: controller plus datapath.
//
// Input channel: in_valid/in_stall carry one word (in_action, in_block_high,
// in_block_low). in_action 0 encrypts, 1 decrypts. A word is taken when
// in_valid is high and in_stall is low; in_stall is high while a block is
// being processed.
// Output channel: out_valid/out_stall carry out_result_high/out_result_low.
// The result sits in an output register, so a new block is taken while the
// previous result still waits.
// Configuration: cfg_valid/cfg_ready write cfg_data to key_high (index 0) or
// key_low (index 1); other indexes are ignored. Writes are taken only while
// no block is in flight or offered. A key write marks the round key table stale.
// Sequencing: with a current key table an accepted word makes ROUNDS+1 passes
// through the single shared round unit, fed from a round key memory with a
// registered read port. The last pass is loaded into the output register and
// raises out_valid, unless a stalled earlier result still holds that register.
// The first block after reset or a key write first runs key expansion, then a
// memory prefetch, before its rounds.
// Reset clears the key to zero and marks the table stale. When the receiver
// stalls, a finished result waits inside the block until the output frees.
`default_nettype none

module block_cipher_128_encrypt_decrypt #(
  parameter int ROUNDS = bc128_pkg::ROUNDS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire logic                            in_action,
  input  wire logic [bc128_pkg::HALF_W-1:0]    in_block_high,
  input  wire logic [bc128_pkg::HALF_W-1:0]    in_block_low,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic [bc128_pkg::HALF_W-1:0]    out_result_high,
  output      logic [bc128_pkg::HALF_W-1:0]    out_result_low,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [bc128_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bc128_pkg::HALF_W-1:0]    cfg_data
);
  import bc128_pkg::*;

  localparam int IDX_W = $clog2(ROUNDS + 1);

  bc_cmd_t          cmd;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] rk_cnt;

  bc128_ctrl #(
    .ROUNDS (ROUNDS),
    .IDX_W  (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cmd       (cmd),
    .cnt       (cnt),
    .rk_cnt    (rk_cnt)
  );

  bc128_dp #(
    .ROUNDS (ROUNDS),
    .IDX_W  (IDX_W)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cnt             (cnt),
    .rk_cnt          (rk_cnt),
    .cfg_data        (cfg_data),
    .in_action       (in_action),
    .in_block_high   (in_block_high),
    .in_block_low    (in_block_low),
    .out_result_high (out_result_high),
    .out_result_low  (out_result_low)
  );

endmodule

`default_nettype wire

@@ design/bc128_ctrl.sv @@
// Controller: sequences key expansion, rounds and result hand-off.
`default_nettype none

module bc128_ctrl #(
  parameter int ROUNDS = bc128_pkg::ROUNDS_DEF,
  parameter int IDX_W  = $clog2(ROUNDS + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [bc128_pkg::CFG_IDX_W-1:0] cfg_index,
  output      bc128_pkg::bc_cmd_t             cmd,
  output      logic [IDX_W-1:0]               cnt,
  output      logic [IDX_W-1:0]               rk_cnt
);
  import bc128_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXPAND,
    S_PREP,
    S_RUN,
    S_HOLD
  } state_t;

  localparam logic [IDX_W-1:0] LAST_RND  = IDX_W'(ROUNDS);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(ROUNDS - 1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             sched_ok_r, sched_ok_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !in_valid;
  assign out_valid = out_valid_r;
  assign cnt       = cnt_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sched_ok_nxt  = sched_ok_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    rk_cnt        = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_HIGH: begin
          cmd.key_wr_hi = 1'b1;
          sched_ok_nxt  = 1'b0;
        end
        REG_KEY_LOW: begin
          cmd.key_wr_lo = 1'b1;
          sched_ok_nxt  = 1'b0;
        end
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        cmd.rk_use_in = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          cnt_nxt     = '0;
          if (!sched_ok_r) begin
            cmd.load_key = 1'b1;
            state_nxt    = S_EXPAND;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end
      S_EXPAND: begin
        cmd.exp_step = 1'b1;
        if (cnt_r == LAST_STEP) begin
          sched_ok_nxt = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_PREP;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_PREP: begin
        cnt_nxt   = '0;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        cmd.round = 1'b1;
        cmd.first = (cnt_r == '0);
        cmd.last  = (cnt_r == LAST_RND);
        if (cnt_r == LAST_RND) begin
          rk_cnt = cnt_r;
          if (out_free) begin
            cmd.out_load       = 1'b1;
            cmd.out_from_round = 1'b1;
            out_valid_nxt      = 1'b1;
            state_nxt          = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end else begin
          rk_cnt  = cnt_r + IDX_W'(1);
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sched_ok_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sched_ok_r  <= sched_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/bc128_dp.sv @@
// Datapath: key registers, round key memory, key schedule step and shared round unit.
`default_nettype none

module bc128_dp #(
  parameter int ROUNDS = bc128_pkg::ROUNDS_DEF,
  parameter int IDX_W  = $clog2(ROUNDS + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bc128_pkg::bc_cmd_t          cmd,
  input  wire logic [IDX_W-1:0]            cnt,
  input  wire logic [IDX_W-1:0]            rk_cnt,
  input  wire logic [bc128_pkg::HALF_W-1:0] cfg_data,
  input  wire logic                        in_action,
  input  wire logic [bc128_pkg::HALF_W-1:0] in_block_high,
  input  wire logic [bc128_pkg::HALF_W-1:0] in_block_low,
  output      logic [bc128_pkg::HALF_W-1:0] out_result_high,
  output      logic [bc128_pkg::HALF_W-1:0] out_result_low
);
  import bc128_pkg::*;

  localparam int               DEPTH   = ROUNDS + 1;
  localparam logic [IDX_W-1:0] RND_IDX = IDX_W'(ROUNDS);

  function automatic logic [WORD_W-1:0] rot_r(input logic [WORD_W-1:0] v, input int n);
    logic [2*WORD_W-1:0] dbl;
    dbl = {v, v};
    return dbl[n +: WORD_W];
  endfunction

  function automatic logic [WORD_W-1:0] circ_mul(input logic [WORD_W-1:0] m,
                                                 input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < WORD_W; k++) begin
      if (m[WORD_W-1-k]) begin
        acc = acc ^ rot_r(v, k);
      end
    end
    return acc;
  endfunction

  function automatic logic [BLOCK_W-1:0] ks_step(input logic [BLOCK_W-1:0] s,
                                                 input logic [WORD_W-1:0]  step);
    logic [WORD_W-1:0] a, b, c, d, t;
    a = s[127:96];
    b = s[95:64];
    c = s[63:32];
    d = s[31:0];
    t = a ^ b ^ c ^ d;
    a = a ^ t;
    b = b ^ t;
    c = c ^ t;
    d = d ^ t;
    a = circ_mul(KS_MAT, a) ^ KS_RC0 ^ step;
    b = rot_r(b, 8) ^ KS_RC1;
    c = rot_r(c, 15) ^ KS_RC2;
    d = rot_r(d, 18) ^ KS_RC3;
    return {a, b, c, d};
  endfunction

  function automatic logic [BLOCK_W-1:0] enc_round(input logic [BLOCK_W-1:0] s);
    logic [WORD_W-1:0] a, b, c, d, t;
    a = s[127:96];
    b = s[95:64];
    c = s[63:32];
    d = s[31:0];
    a = a ^ d;
    d = d ^ (a & b);
    a = a ^ (b & c);
    b = b ^ (c & d);
    c = c ^ (a & d);
    c = c ^ b;
    b = b ^ a;
    d = ~d;
    t = c;
    c = d;
    d = t;
    return {circ_mul(ENC_MAT0, a), circ_mul(ENC_MAT1, b),
            circ_mul(ENC_MAT2, c), circ_mul(ENC_MAT3, d)};
  endfunction

  function automatic logic [BLOCK_W-1:0] dec_round(input logic [BLOCK_W-1:0] s);
    logic [WORD_W-1:0] a, b, c, d, t;
    a = circ_mul(DEC_MAT0, s[127:96]);
    b = circ_mul(DEC_MAT1, s[95:64]);
    c = circ_mul(DEC_MAT2, s[63:32]);
    d = circ_mul(DEC_MAT3, s[31:0]);
    t = c;
    c = d;
    d = t;
    d = ~d;
    b = b ^ a;
    c = c ^ b;
    c = c ^ (a & d);
    b = b ^ (c & d);
    a = a ^ (b & c);
    d = d ^ (a & b);
    a = a ^ d;
    return {a, b, c, d};
  endfunction

  logic [HALF_W-1:0]  key_hi_r, key_lo_r;
  logic [BLOCK_W-1:0] kstate_r, kstate_nxt;
  logic [BLOCK_W-1:0] state_r, state_nxt;
  logic [BLOCK_W-1:0] result_r;
  logic               action_r;
  logic [BLOCK_W-1:0] rk_mem [DEPTH];
  logic [BLOCK_W-1:0] rk_rd_r;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic [BLOCK_W-1:0] wr_data;
  logic               wr_en;
  logic               rd_act;
  logic [BLOCK_W-1:0] mix_in, round_out, step_out;

  assign rd_act  = cmd.rk_use_in ? in_action : action_r;
  assign rd_addr = rd_act ? (RND_IDX - rk_cnt) : rk_cnt;

  assign step_out = ks_step(kstate_r, WORD_W'(cnt));
  assign wr_en    = cmd.load_key || cmd.exp_step;
  assign wr_addr  = cmd.load_key ? '0 : (cnt + IDX_W'(1));
  assign wr_data  = cmd.load_key ? {key_hi_r, key_lo_r} : step_out;

  always_comb begin
    if (!action_r) begin
      mix_in    = state_r ^ rk_rd_r;
      round_out = cmd.last ? mix_in : enc_round(mix_in);
    end else begin
      mix_in    = cmd.first ? state_r : dec_round(state_r);
      round_out = mix_in ^ rk_rd_r;
    end
  end

  always_comb begin
    kstate_nxt = kstate_r;
    if (cmd.load_key) begin
      kstate_nxt = {key_hi_r, key_lo_r};
    end else if (cmd.exp_step) begin
      kstate_nxt = step_out;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (cmd.load_in) begin
      state_nxt = {in_block_high, in_block_low};
    end else if (cmd.round) begin
      state_nxt = round_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else begin
      if (cmd.key_wr_hi) begin
        key_hi_r <= cfg_data;
      end
      if (cmd.key_wr_lo) begin
        key_lo_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rk_mem[wr_addr] <= wr_data;
    end
    rk_rd_r <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    kstate_r <= kstate_nxt;
    state_r  <= state_nxt;
    if (cmd.load_in) begin
      action_r <= in_action;
    end
    if (cmd.out_load) begin
      result_r <= cmd.out_from_round ? round_out : state_r;
    end
  end

  assign out_result_high = result_r[127:64];
  assign out_result_low  = result_r[63:0];

endmodule

`default_nettype wire

@@ design/bc128_chk.sv @@
// Port-level checker for the block cipher top level, with its bind.
`default_nettype none

module bc128_chk (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [bc128_pkg::HALF_W-1:0]    out_result_high,
  input wire logic [bc128_pkg::HALF_W-1:0]    out_result_low,
  input wire logic                            cfg_valid,
  input wire logic                            cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_high)
                               && $stable(out_result_low))
    else $error("result word changed or dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !cfg_ready)
    else $error("block not busy after taking a word");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared one cycle after taking a word");

  a_cfg_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> !in_stall)
    else $error("key write taken while a block is in flight");

endmodule

bind block_cipher_128_encrypt_decrypt bc128_chk u_bc128_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_high (out_result_high),
  .out_result_low  (out_result_low),
  .cfg_valid       (cfg_valid),
  .cfg_ready       (cfg_ready)
);

`default_nettype wire

@@ test/block_cipher_128_encrypt_decrypt_checker.sv @@
// Action codes and the scoreboard that predicts and checks every cipher result.
`timescale 1ns / 1ps

package bc128_tb_pkg;
  typedef enum logic {ACT_ENCRYPT = 1'b0, ACT_DECRYPT = 1'b1} cipher_action_t;
endpackage

module block_cipher_128_encrypt_decrypt_checker #(
  parameter int ROUNDS = bc128_pkg::ROUNDS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic                            in_stall,
  input  wire logic                            in_action,
  input  wire logic [bc128_pkg::HALF_W-1:0]    in_block_high,
  input  wire logic [bc128_pkg::HALF_W-1:0]    in_block_low,
  input  wire logic                            out_valid,
  input  wire logic                            out_stall,
  input  wire logic [bc128_pkg::HALF_W-1:0]    out_result_high,
  input  wire logic [bc128_pkg::HALF_W-1:0]    out_result_low,
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_ready,
  input  wire logic [bc128_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bc128_pkg::HALF_W-1:0]    cfg_data,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   checked
);
  import bc128_pkg::*;
  import bc128_tb_pkg::*;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [BLOCK_W-1:0] block_t;

  logic [HALF_W-1:0] key_high;
  logic [HALF_W-1:0] key_low;
  block_t            round_keys [0:ROUNDS];
  block_t            predicted_outputs [$];

  function automatic word_t ror(word_t v, int n);
    return (v >> n) | (v << (WORD_W - n));
  endfunction

  function automatic word_t circ_mul(word_t m, word_t v);
    word_t acc;
    acc = '0;
    for (int k = 0; k < WORD_W; k++) begin
      if (m[WORD_W-1-k]) acc ^= ror(v, k);
    end
    return acc;
  endfunction

  function automatic void expand_round_keys();
    word_t a, b, c, d, t;
    {a, b, c, d} = {key_high, key_low};
    round_keys[0] = {a, b, c, d};
    for (int s = 0; s < ROUNDS; s++) begin
      t = a ^ b ^ c ^ d;
      a ^= t;
      b ^= t;
      c ^= t;
      d ^= t;
      a = circ_mul(KS_MAT, a) ^ KS_RC0 ^ word_t'(s);
      b = ror(b, 8) ^ KS_RC1;
      c = ror(c, 15) ^ KS_RC2;
      d = ror(d, 18) ^ KS_RC3;
      round_keys[s+1] = {a, b, c, d};
    end
  endfunction

  function automatic block_t fwd_round(block_t s);
    word_t a, b, c, d, t;
    {a, b, c, d} = s;
    a ^= d;
    d ^= a & b;
    a ^= b & c;
    b ^= c & d;
    c ^= a & d;
    c ^= b;
    b ^= a;
    d = ~d;
    t = c;
    c = d;
    d = t;
    return {circ_mul(ENC_MAT0, a), circ_mul(ENC_MAT1, b),
            circ_mul(ENC_MAT2, c), circ_mul(ENC_MAT3, d)};
  endfunction

  function automatic block_t inv_round(block_t s);
    word_t a, b, c, d, t;
    a = circ_mul(DEC_MAT0, s[127:96]);
    b = circ_mul(DEC_MAT1, s[95:64]);
    c = circ_mul(DEC_MAT2, s[63:32]);
    d = circ_mul(DEC_MAT3, s[31:0]);
    t = c;
    c = d;
    d = t;
    d = ~d;
    b ^= a;
    c ^= b;
    c ^= a & d;
    b ^= c & d;
    a ^= b & c;
    d ^= a & b;
    a ^= d;
    return {a, b, c, d};
  endfunction

  function automatic block_t encrypt_block(block_t x);
    for (int r = 0; r < ROUNDS; r++) begin
      x = fwd_round(x ^ round_keys[r]);
    end
    return x ^ round_keys[ROUNDS];
  endfunction

  function automatic block_t decrypt_block(block_t x);
    x ^= round_keys[ROUNDS];
    for (int r = 0; r < ROUNDS; r++) begin
      x = inv_round(x) ^ round_keys[ROUNDS-1-r];
    end
    return x;
  endfunction

  function automatic void flag(string msg);
    fail_count++;
    $display("%0t: %s", $time, msg);
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  always @(posedge clk) begin : scoreboard
    block_t got, want;
    if (!rst_n) begin
      key_high = '0;
      key_low  = '0;
      expand_round_keys();
      predicted_outputs.delete();
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_HIGH: begin
            key_high = cfg_data;
            expand_round_keys();
          end
          REG_KEY_LOW: begin
            key_low = cfg_data;
            expand_round_keys();
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {out_result_high, out_result_low};
        if (predicted_outputs.size() == 0) begin
          flag($sformatf("result word %h with none expected", got));
        end else begin
          want = predicted_outputs.pop_front();
          checked++;
          if (got[127:64] !== want[127:64])
            flag($sformatf("result_high expected %h, actual %h", want[127:64], got[127:64]));
          if (got[63:0] !== want[63:0])
            flag($sformatf("result_low expected %h, actual %h", want[63:0], got[63:0]));
        end
      end
      if (in_valid && !in_stall) begin
        if (cipher_action_t'(in_action) == ACT_DECRYPT)
          predicted_outputs.push_back(decrypt_block({in_block_high, in_block_low}));
        else
          predicted_outputs.push_back(encrypt_block({in_block_high, in_block_low}));
      end
      pending = predicted_outputs.size();
    end
  end

endmodule

@@ test/block_cipher_128_encrypt_decrypt_tb.sv @@
// Stimulus and verdict for the 128-bit block cipher regression.
`timescale 1ns / 1ps

module block_cipher_128_encrypt_decrypt_tb;
  import bc128_pkg::*;
  import bc128_tb_pkg::*;

  localparam int PHASES           = 10;
  localparam int BLOCKS_PER_PHASE = 123;
  localparam int SETTLE_CYCLES    = 40;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic                 in_action     = 1'b0;
  logic [HALF_W-1:0]    in_block_high = '0;
  logic [HALF_W-1:0]    in_block_low  = '0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic [HALF_W-1:0]    out_result_high;
  logic [HALF_W-1:0]    out_result_low;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = REG_KEY_HIGH;
  logic [HALF_W-1:0]    cfg_data      = '0;

  int fail_count;
  int pending;
  int checked;
  int encrypt_count;
  int decrypt_count;
  int key_phases;
  bit gaps_on  = 1'b1;
  bit stall_on = 1'b1;

  block_cipher_128_encrypt_decrypt u_top (.*);

  block_cipher_128_encrypt_decrypt_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("block_cipher_128_encrypt_decrypt regression: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [HALF_W-1:0] rand_half();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return {$urandom(), $urandom()};
    if (r < 78) return '0;
    if (r < 86) return '1;
    if (r < 93) return HALF_W'(1) << $urandom_range(0, HALF_W - 1);
    return {$urandom(), $urandom()} & {$urandom(), $urandom()} & {$urandom(), $urandom()};
  endfunction

  task automatic send_block(input cipher_action_t act, input logic [HALF_W-1:0] hi, lo);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_action     <= act;
    in_block_high <= hi;
    in_block_low  <= lo;
    do @(posedge clk); while (in_stall);
    if (act == ACT_ENCRYPT) encrypt_count++;
    else decrypt_count++;
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic write_unmapped();
    for (int i = int'(REG_KEY_LOW) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), rand_half());
  endtask

  initial begin : result_backpressure
    int r;
    int len;
    bit hold;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        hold = 1'b0;
        len  = $urandom_range(1, 6);
      end else if (r < 88) begin
        hold = 1'b1;
        len  = $urandom_range(1, 3);
      end else if (r < 96) begin
        hold = 1'b1;
        len  = $urandom_range(8, 40);
      end else begin
        hold = 1'b0;
        len  = $urandom_range(50, 150);
      end
      repeat (len) @(negedge clk) out_stall <= hold && stall_on;
    end
  end

  initial begin : stimulus
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // all-zero key left by reset
    key_phases = 1;
    send_block(ACT_ENCRYPT, '0, '0);
    send_block(ACT_DECRYPT, '0, '0);
    send_block(ACT_ENCRYPT, '1, '1);
    send_block(ACT_DECRYPT, '1, '1);
    send_block(ACT_ENCRYPT, 64'h8000_0000_0000_0000, 64'h1);
    send_block(ACT_DECRYPT, 64'h1, 64'h8000_0000_0000_0000);
    drain();

    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LOW, '1);
    key_phases++;
    send_block(ACT_ENCRYPT, '0, '0);
    send_block(ACT_DECRYPT, '1, '1);
    send_block(ACT_ENCRYPT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    send_block(ACT_DECRYPT, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    drain();

    // high half only
    write_reg(REG_KEY_HIGH, 64'h0123_4567_89ab_cdef);
    key_phases++;
    send_block(ACT_ENCRYPT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_block(ACT_DECRYPT, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    drain();

    // unmapped indexes must leave the schedule intact
    write_unmapped();
    send_block(ACT_ENCRYPT, '0, '1);
    send_block(ACT_DECRYPT, '1, '0);
    drain();

    write_reg(REG_KEY_LOW, '0);
    key_phases++;
    send_block(ACT_ENCRYPT, 64'h0000_0000_8000_0000, 64'h0000_0001_0000_0000);
    send_block(ACT_DECRYPT, 64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      gaps_on  = (phase % 3 != 1);
      stall_on = (phase % 4 != 2);
      if (phase == 0) begin
        write_reg(REG_KEY_HIGH, '0);
        write_reg(REG_KEY_LOW, '0);
      end else if (phase == 1) begin
        write_reg(REG_KEY_HIGH, '1);
        write_reg(REG_KEY_LOW, '1);
      end else begin
        if ($urandom_range(0, 3) != 0) write_reg(REG_KEY_HIGH, rand_half());
        if ($urandom_range(0, 3) != 0) write_reg(REG_KEY_LOW, rand_half());
        if ($urandom_range(0, 2) == 0) write_unmapped();
      end
      key_phases++;
      for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
        if ($urandom_range(0, 49) == 0) drain();
        send_block(cipher_action_t'($urandom_range(0, 1)), rand_half(), rand_half());
      end
    end

    drain();
    $display("covered %0d encrypt and %0d decrypt blocks across %0d key phases",
             encrypt_count, decrypt_count, key_phases);
    $display("%0d results compared, %0d failures", checked, fail_count);
    if (fail_count == 0) begin
      $display("block_cipher_128_encrypt_decrypt regression: pass");
    end else begin
      $display("block_cipher_128_encrypt_decrypt regression: fail");
    end
    $finish;
  end

endmodule
